// ===== sv/wps_pkg.sv =====
// Shared constants, types and command/status bundles for the weighted partner select block.
package wps_pkg;

  // Sizes of the particle lists
  localparam int Particles = 256;
  localparam int Slots     = 16;

  localparam int PartW  = $clog2(Particles);
  localparam int SlotW  = $clog2(Slots);
  localparam int CntW   = $clog2(Slots + 1);
  localparam int EntAW  = PartW + SlotW;

  // Field widths
  localparam int ProbW  = 32;
  localparam int RxnW   = 10;
  localparam int UniW   = 16;
  localparam int ScaleW = 8;
  localparam int OffW   = ScaleW;            // (uniform * scale) >> UniW
  localparam int AccW   = ProbW + SlotW;     // exact sum of Slots probabilities
  localparam int KindW  = 2;

  localparam logic [ScaleW-1:0] ScaleRst = ScaleW'(2);

  // Input word kinds
  typedef enum logic [KindW-1:0] {
    KIND_WRITE  = 2'd0,
    KIND_COUNT  = 2'd1,
    KIND_CHOOSE = 2'd2
  } kind_e;

  // One list entry as stored
  typedef struct packed {
    logic [ProbW-1:0] prob;
    logic [PartW-1:0] partner;
    logic [RxnW-1:0]  reaction;
  } wps_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic take;            // latch a choose word
    logic wr_entry;        // write one list entry
    logic wr_count;        // write one list count
    logic cnt_rd_partner;  // count read address: partner instead of chooser
    logic load_len;        // length of the next scan from the count read
    logic scan_clr;        // restart the scan pipeline
    logic scan_sum;        // scan: total of own list
    logic scan_sel;        // scan: pick own slot
    logic scan_part;       // scan: search partner list
    logic set_reacted;     // mark the choose as reacted
    logic load_out;        // move result into the output register
  } wps_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;        // count read gave an empty list
    logic scan_done;       // scan pipeline drained
    logic hit;             // both random numbers at or below the total
  } wps_sts_t;

endpackage

// ===== sv/wps_ctrl.sv =====
// Sequencer for the choose flow and the handshake of both channels.
module wps_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [wps_pkg::KindW-1:0]   kind_i,
  output logic                        in_stall_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  wps_pkg::wps_sts_t           sts_i,
  output wps_pkg::wps_cmd_t           cmd_o
);
  import wps_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_RDCNT  = 10'b0000000010,
    S_CHKCNT = 10'b0000000100,
    S_SUM    = 10'b0000001000,
    S_TEST   = 10'b0000010000,
    S_SEL    = 10'b0000100000,
    S_PCNT   = 10'b0001000000,
    S_PCHK   = 10'b0010000000,
    S_PSCAN  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_vld_q, out_vld_d;
  logic   accept;
  logic   load_out;

  // Input side: words only taken while idle
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign load_out   = (state_q == S_DONE) && (!out_vld_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (kind_i == KIND_CHOOSE)) state_d = S_RDCNT;
      end
      S_RDCNT:  state_d = S_CHKCNT;
      S_CHKCNT: state_d = sts_i.cnt_zero ? S_DONE : S_SUM;
      S_SUM: begin
        if (sts_i.scan_done) state_d = S_TEST;
      end
      S_TEST:   state_d = sts_i.hit ? S_SEL : S_DONE;
      S_SEL: begin
        if (sts_i.scan_done) state_d = S_PCNT;
      end
      S_PCNT:   state_d = S_PCHK;
      S_PCHK:   state_d = S_PSCAN;
      S_PSCAN: begin
        if (sts_i.scan_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o                = '0;
    cmd_o.take           = accept && (kind_i == KIND_CHOOSE);
    cmd_o.wr_entry       = accept && (kind_i == KIND_WRITE);
    cmd_o.wr_count       = accept && (kind_i == KIND_COUNT);
    cmd_o.cnt_rd_partner = (state_q == S_PCNT);
    cmd_o.load_len       = (state_q == S_CHKCNT) || (state_q == S_PCHK);
    cmd_o.scan_clr       = (state_q == S_CHKCNT) || (state_q == S_TEST) ||
                           (state_q == S_PCHK);
    cmd_o.scan_sum       = (state_q == S_SUM);
    cmd_o.scan_sel       = (state_q == S_SEL);
    cmd_o.scan_part      = (state_q == S_PSCAN);
    cmd_o.set_reacted    = (state_q == S_TEST) && sts_i.hit;
    cmd_o.load_out       = load_out;
  end

  // Output word valid
  always_comb begin
    out_vld_d = out_vld_q;
    priority if (load_out) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

endmodule

// ===== sv/wps_dpath.sv =====
// List memories, scan pipeline, running sums and result register.
module wps_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wps_pkg::wps_cmd_t             cmd_i,
  output wps_pkg::wps_sts_t             sts_o,
  input  logic                          cfg_we_i,
  input  logic [wps_pkg::ScaleW-1:0]    cfg_wdata_i,
  input  logic [wps_pkg::PartW-1:0]     particle_i,
  input  logic [wps_pkg::SlotW-1:0]     slot_i,
  input  logic [wps_pkg::CntW-1:0]      count_i,
  input  logic [wps_pkg::ProbW-1:0]     probability_i,
  input  logic [wps_pkg::PartW-1:0]     partner_i,
  input  logic [wps_pkg::RxnW-1:0]      reaction_i,
  input  logic [wps_pkg::ProbW-1:0]     random_value_i,
  input  logic [wps_pkg::UniW-1:0]      refine_uniform_i,
  output logic                          reacted_o,
  output logic [wps_pkg::SlotW-1:0]     self_slot_o,
  output logic [wps_pkg::PartW-1:0]     partner_id_o,
  output logic [wps_pkg::SlotW-1:0]     partner_slot_o,
  output logic                          partner_slot_valid_o
);
  import wps_pkg::*;

  // Refinement scale register
  logic [ScaleW-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleRst;
    end else if (cfg_we_i) begin
      scale_q <= cfg_wdata_i;
    end
  end

  // Choose word and refined random number
  logic [PartW-1:0]       who_q;
  logic [ProbW-1:0]       rnum_q;
  logic [UniW-1:0]        runi_q;
  logic [UniW+ScaleW-1:0] prod;
  logic [OffW-1:0]        off_q;
  logic [ProbW:0]         r2_q;

  assign prod = runi_q * scale_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      who_q  <= particle_i;
      rnum_q <= random_value_i;
      runi_q <= refine_uniform_i;
    end
    off_q <= prod[UniW+ScaleW-1:UniW];
    r2_q  <= {1'b0, rnum_q} + {{(ProbW+1-OffW){1'b0}}, off_q};
  end

  // List counts: memory plus per-entry valid bits, unwritten reads as zero
  logic [CntW-1:0]      lc_mem [Particles];
  logic [Particles-1:0] lc_vld_q;
  logic [CntW-1:0]      lc_rd_q;
  logic                 lc_rv_q;
  logic [PartW-1:0]     lc_raddr;
  logic [CntW-1:0]      cnt_val;
  logic [CntW-1:0]      cnt_clamp;
  logic [PartW-1:0]     pid_q;

  assign cnt_clamp = (count_i > CntW'(Slots)) ? CntW'(Slots) : count_i;
  assign lc_raddr  = cmd_i.cnt_rd_partner ? pid_q : who_q;
  assign cnt_val   = lc_rv_q ? lc_rd_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lc_vld_q <= '0;
    end else if (cmd_i.wr_count) begin
      lc_vld_q[particle_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_count) begin
      lc_mem[particle_i] <= cnt_clamp;
    end
    lc_rd_q <= lc_mem[lc_raddr];
    lc_rv_q <= lc_vld_q[lc_raddr];
  end

  // Entry memory
  wps_entry_t       ent_mem [Particles*Slots];
  wps_entry_t       ent_rd_q;
  wps_entry_t       ent_wr;
  logic [EntAW-1:0] ent_raddr;
  logic [CntW-1:0]  idx_q;
  logic [PartW-1:0] scan_base;

  assign ent_wr.prob     = probability_i;
  assign ent_wr.partner  = partner_i;
  assign ent_wr.reaction = reaction_i;
  assign scan_base       = cmd_i.scan_part ? pid_q : who_q;
  assign ent_raddr       = {scan_base, idx_q[SlotW-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      ent_mem[{particle_i, slot_i}] <= ent_wr;
    end
    ent_rd_q <= ent_mem[ent_raddr];
  end

  // Scan pipeline: one read issued per cycle, data in the next cycle
  logic [CntW-1:0]  len_q;
  logic             dv_q;
  logic [SlotW-1:0] didx_q;
  logic             scan_en;
  logic             issue;

  assign scan_en = cmd_i.scan_sum || cmd_i.scan_sel || cmd_i.scan_part;
  assign issue   = scan_en && (idx_q < len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      dv_q  <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      idx_q <= '0;
      dv_q  <= 1'b0;
    end else begin
      dv_q <= issue;
      if (issue) idx_q <= idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_len) len_q <= cnt_val;
    didx_q <= idx_q[SlotW-1:0];
  end

  // Running sum, slot pick and partner search
  logic [AccW-1:0]  acc_q;
  logic [AccW-1:0]  run_nx;
  logic             sel_hit;
  logic             last_slot;
  logic             found_q;
  logic [SlotW-1:0] k_q;
  logic [ProbW-1:0] pm_q;
  logic [RxnW-1:0]  rxn_q;
  logic             reacted_q;
  logic             pvalid_q;
  logic [SlotW-1:0] pslot_q;
  logic             stop_q;
  logic             prob_eq;

  assign run_nx    = acc_q + {{(AccW-ProbW){1'b0}}, ent_rd_q.prob};
  assign last_slot = (didx_q == SlotW'(len_q - CntW'(1)));
  assign sel_hit   = ({{(AccW-ProbW-1){1'b0}}, r2_q} <= run_nx) || last_slot;
  assign prob_eq   = (ent_rd_q.prob == pm_q);

  always_ff @(posedge clk_i) begin
    // accumulator: total in the sum scan, running sum in the pick scan
    if (cmd_i.scan_clr) begin
      acc_q <= '0;
    end else if (dv_q && (cmd_i.scan_sum || (cmd_i.scan_sel && !found_q))) begin
      acc_q <= run_nx;
    end

    if (cmd_i.scan_clr) begin
      found_q <= 1'b0;
    end else if (cmd_i.scan_sel && dv_q && !found_q && sel_hit) begin
      found_q <= 1'b1;
      k_q     <= didx_q;
      pid_q   <= ent_rd_q.partner;
      pm_q    <= ent_rd_q.prob;
      rxn_q   <= ent_rd_q.reaction;
    end

    if (cmd_i.take) begin
      reacted_q <= 1'b0;
    end else if (cmd_i.set_reacted) begin
      reacted_q <= 1'b1;
    end

    // reverse match: first equal probability and reaction, else last equal probability
    if (cmd_i.scan_clr) begin
      pvalid_q <= 1'b0;
      pslot_q  <= '0;
      stop_q   <= 1'b0;
    end else if (cmd_i.scan_part && dv_q && !stop_q && prob_eq) begin
      pvalid_q <= 1'b1;
      pslot_q  <= didx_q;
      stop_q   <= (ent_rd_q.reaction == rxn_q);
    end
  end

  // Status
  assign sts_o.cnt_zero  = (cnt_val == '0);
  assign sts_o.scan_done = scan_en && !issue && !dv_q;
  assign sts_o.hit       = ({{(AccW-ProbW){1'b0}}, rnum_q} <= acc_q) &&
                           ({{(AccW-ProbW-1){1'b0}}, r2_q} <= acc_q);

  // Output word register, fields zero when nothing reacted
  logic             o_reacted_q;
  logic [SlotW-1:0] o_self_q;
  logic [PartW-1:0] o_pid_q;
  logic [SlotW-1:0] o_pslot_q;
  logic             o_pvalid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_reacted_q <= reacted_q;
      o_self_q    <= reacted_q ? k_q : '0;
      o_pid_q     <= reacted_q ? pid_q : '0;
      o_pslot_q   <= (reacted_q && pvalid_q) ? pslot_q : '0;
      o_pvalid_q  <= reacted_q && pvalid_q;
    end
  end

  assign reacted_o            = o_reacted_q;
  assign self_slot_o          = o_self_q;
  assign partner_id_o         = o_pid_q;
  assign partner_slot_o       = o_pslot_q;
  assign partner_slot_valid_o = o_pvalid_q;

endmodule

// ===== sv/weighted_partner_select_core.sv =====
// Top level of the weighted partner select block: controller, datapath and checks.
//
// Input channel (in_valid_i / in_stall_o) carries one word per item: a list
// entry write, a list count write, or a choose. Writes give no output word
// and leave the block ready in the next cycle. A choose gives exactly one
// output word (reacted, own slot, partner id, partner slot). A choose reads
// the entry memory through its single read port, one entry per cycle, over
// the own list twice and the partner list once; it reads the own list only
// once when the random number misses the total, and none for an empty list.
// Words are taken only while no choose is in progress.
// The output register holds a finished word while out_stall_i is high; the
// block goes back to taking input meanwhile, and a later choose waits at its
// end until the register is free.
// Reset empties every list (count bits cleared at once) and sets the
// refinement scale to 2. cfg_we_i writes the scale.
module weighted_partner_select_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wps_pkg::ScaleW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wps_pkg::KindW-1:0]     kind_i,
  input  logic [wps_pkg::PartW-1:0]     particle_i,
  input  logic [wps_pkg::SlotW-1:0]     slot_i,
  input  logic [wps_pkg::CntW-1:0]      count_i,
  input  logic [wps_pkg::ProbW-1:0]     probability_i,
  input  logic [wps_pkg::PartW-1:0]     partner_i,
  input  logic [wps_pkg::RxnW-1:0]      reaction_i,
  input  logic [wps_pkg::ProbW-1:0]     random_value_i,
  input  logic [wps_pkg::UniW-1:0]      refine_uniform_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          reacted_o,
  output logic [wps_pkg::SlotW-1:0]     self_slot_o,
  output logic [wps_pkg::PartW-1:0]     partner_id_o,
  output logic [wps_pkg::SlotW-1:0]     partner_slot_o,
  output logic                          partner_slot_valid_o
);
  import wps_pkg::*;

  wps_cmd_t cmd;
  wps_sts_t sts;

  wps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wps_dpath u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_we_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .particle_i           (particle_i),
    .slot_i               (slot_i),
    .count_i              (count_i),
    .probability_i        (probability_i),
    .partner_i            (partner_i),
    .reaction_i           (reaction_i),
    .random_value_i       (random_value_i),
    .refine_uniform_i     (refine_uniform_i),
    .reacted_o            (reacted_o),
    .self_slot_o          (self_slot_o),
    .partner_id_o         (partner_id_o),
    .partner_slot_o       (partner_slot_o),
    .partner_slot_valid_o (partner_slot_valid_o)
  );

  // An accepted choose occupies the block in the next cycle
  a_choose_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == KIND_CHOOSE)) |=> in_stall_o)
    else $error("choose accepted but block not busy");

  // Write words never occupy the block
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i != KIND_CHOOSE)) |=> !in_stall_o)
    else $error("write word left the block busy");

  // A new output word only comes out of a choose in progress
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a choose");

  // No reaction means all other fields are zero
  a_no_react_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !reacted_o) |->
      (self_slot_o == '0) && (partner_id_o == '0) &&
      (partner_slot_o == '0) && !partner_slot_valid_o)
    else $error("fields set without reaction");

endmodule
